### rtl/core/segment_rectangle_intersect_core_assert.svh
// assertion helpers for the segment rectangle intersect core
`ifndef SEGMENT_RECTANGLE_INTERSECT_CORE_ASSERT_SVH
`define SEGMENT_RECTANGLE_INTERSECT_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SRI_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sri assertion failed");

// antecedent implies consequent in the next cycle
`define SRI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sri assertion failed");

`endif

### rtl/core/sri_pkg.sv
package sri_pkg;

    // default geometry formats
    localparam int COORD_WIDTH_DEF = 21;
    localparam int COORD_FRAC_DEF  = 10;
    localparam int UNIT_FRAC_DEF   = 19;

    // epsilon register width and queue depth
    localparam int EPS_WIDTH   = 20;
    localparam int FIFO_DEPTH  = 4;
    localparam int REASON_W    = 3;

    // result reason codes
    typedef enum logic [REASON_W-1:0] {
        RSN_HIT         = 3'd0,
        RSN_DEGENERATE  = 3'd1,
        RSN_PARALLEL    = 3'd2,
        RSN_OUT_SEGMENT = 3'd3,
        RSN_OUT_RECT    = 3'd4
    } reason_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CENTER   = 3'd0,
        CFG_NORMAL   = 3'd1,
        CFG_RIGHT    = 3'd2,
        CFG_UP       = 3'd3,
        CFG_SIZE     = 3'd4,
        CFG_LEN_EPS  = 3'd5,
        CFG_PAR_EPS  = 3'd6
    } cfg_index_t;

    // queue control and status
    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

### rtl/core/sri_fifo.sv
`include "segment_rectangle_intersect_core_assert.svh"

module sri_fifo #(
    parameter int DATA_WIDTH = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sri_pkg::fifo_ctrl_t   ctrl,
    input  logic [DATA_WIDTH-1:0] wr_data,
    output sri_pkg::fifo_stat_t   stat,
    output logic [DATA_WIDTH-1:0] rd_data
);
    import sri_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [DATA_WIDTH-1:0] store_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W-1:0]      wr_ptr_next, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    // pointer wrap and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctrl.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (ctrl.pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop) begin
            count_next = count_reg + 1'b1;
        end else if (!ctrl.push && ctrl.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // word storage
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = store_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

    `SRI_ASSERT_IMPLY(a_push_room, aclk, aresetn, ctrl.push, !stat.full)
    `SRI_ASSERT_IMPLY(a_pop_data, aclk, aresetn, ctrl.pop, !stat.empty)
    `SRI_ASSERT_NEXT(a_count_up, aclk, aresetn, ctrl.push && !ctrl.pop, count_reg == $past(count_reg) + 1'b1)

endmodule

### rtl/core/sri_front.sv
module sri_front #(
    parameter int COORD_WIDTH = sri_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_start_x,
    input  logic signed [COORD_WIDTH-1:0] s_start_y,
    input  logic signed [COORD_WIDTH-1:0] s_start_z,
    input  logic signed [COORD_WIDTH-1:0] s_end_x,
    input  logic signed [COORD_WIDTH-1:0] s_end_y,
    input  logic signed [COORD_WIDTH-1:0] s_end_z,
    input  logic [3*COORD_WIDTH-1:0]      rect_center,
    input  logic [3*COORD_WIDTH-1:0]      rect_normal,
    input  logic [sri_pkg::EPS_WIDTH-1:0] length_epsilon,
    input  logic [sri_pkg::EPS_WIDTH-1:0] parallel_epsilon,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [3*COORD_WIDTH + 3*(COORD_WIDTH+1) + 2*(2*COORD_WIDTH+3)
                  + sri_pkg::REASON_W - 1:0] q_data
);
    import sri_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int PW  = DW + W;
    localparam int SW  = PW + 2;
    localparam int MW  = SW;
    localparam int LW  = 2 * DW + 1;
    localparam int EW  = EPS_WIDTH;
    localparam int H   = (MW + 1) / 2;
    localparam int LH  = (LW + 1) / 2;
    localparam int DGW = (LW > 2 * EW) ? LW : 2 * EW;
    localparam int CW  = (2 * MW > 2 * EW + LW) ? 2 * MW : 2 * EW + LW;

    logic en;
    logic valid_reg [5];

    logic signed [W-1:0] in_s [3];
    logic signed [W-1:0] in_e [3];
    logic signed [W-1:0] cen [3];
    logic signed [W-1:0] nrm [3];

    assign in_s[0] = s_start_x;
    assign in_s[1] = s_start_y;
    assign in_s[2] = s_start_z;
    assign in_e[0] = s_end_x;
    assign in_e[1] = s_end_y;
    assign in_e[2] = s_end_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cen[i] = rect_center[i*W +: W];
            nrm[i] = rect_normal[i*W +: W];
        end
    end

    // stall the whole front when its last word cannot enter the queue
    assign en      = !valid_reg[4] || !q_full;
    assign s_ready = en;
    assign q_push  = valid_reg[4] && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 5; k++) valid_reg[k] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= s_valid;
            for (int k = 1; k < 5; k++) valid_reg[k] <= valid_reg[k-1];
        end
    end

    // stage 1: direction and centre offset
    logic signed [W-1:0]  s1_reg [3];
    logic signed [DW-1:0] d1_reg [3];
    logic signed [DW-1:0] cs1_reg [3];
    logic signed [DW-1:0] d_next [3];
    logic signed [DW-1:0] cs_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_next[i]  = DW'(in_e[i]) - DW'(in_s[i]);
            cs_next[i] = DW'(cen[i]) - DW'(in_s[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg  <= in_s;
            d1_reg  <= d_next;
            cs1_reg <= cs_next;
        end
    end

    // stage 2: component products
    logic signed [W-1:0]    s2_reg [3];
    logic signed [DW-1:0]   d2_reg [3];
    logic signed [2*DW-1:0] dd2_reg [3];
    logic signed [PW-1:0]   dn2_reg [3];
    logic signed [PW-1:0]   cn2_reg [3];
    logic [2*EW-1:0]        leps2_2_reg, peps2_2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg <= s1_reg;
            d2_reg <= d1_reg;
            for (int i = 0; i < 3; i++) begin
                dd2_reg[i] <= d1_reg[i] * d1_reg[i];
                dn2_reg[i] <= d1_reg[i] * nrm[i];
                cn2_reg[i] <= cs1_reg[i] * nrm[i];
            end
            leps2_2_reg <= length_epsilon * length_epsilon;
            peps2_2_reg <= parallel_epsilon * parallel_epsilon;
        end
    end

    // stage 3: dot products
    logic signed [W-1:0]  s3_reg [3];
    logic signed [DW-1:0] d3_reg [3];
    logic [LW-1:0]        len2_3_reg;
    logic signed [SW-1:0] den3_reg, num3_reg;
    logic [2*EW-1:0]      leps2_3_reg, peps2_3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_reg      <= s2_reg;
            d3_reg      <= d2_reg;
            len2_3_reg  <= LW'(dd2_reg[0]) + LW'(dd2_reg[1]) + LW'(dd2_reg[2]);
            den3_reg    <= SW'(dn2_reg[0]) + SW'(dn2_reg[1]) + SW'(dn2_reg[2]);
            num3_reg    <= SW'(cn2_reg[0]) + SW'(cn2_reg[1]) + SW'(cn2_reg[2]);
            leps2_3_reg <= leps2_2_reg;
            peps2_3_reg <= peps2_2_reg;
        end
    end

    // stage 4: magnitudes, simple tests and partial squares
    logic [MW-1:0] aden_next, anum_next;
    logic          deg_next, zero_next, outs_next;

    always_comb begin
        aden_next = den3_reg[SW-1] ? MW'(-den3_reg) : MW'(den3_reg);
        anum_next = num3_reg[SW-1] ? MW'(-num3_reg) : MW'(num3_reg);
        deg_next  = DGW'(len2_3_reg) < DGW'(leps2_3_reg);
        zero_next = (den3_reg == '0);
        outs_next = ((num3_reg != '0) && (num3_reg[SW-1] != den3_reg[SW-1]))
                    || (anum_next > aden_next);
    end

    logic signed [W-1:0]     s4_reg [3];
    logic signed [DW-1:0]    d4_reg [3];
    logic [MW-1:0]           aden4_reg, anum4_reg;
    logic                    deg4_reg, zero4_reg, outs4_reg;
    logic [2*H-1:0]          pll4_reg;
    logic [MW-1:0]           plh4_reg;
    logic [2*(MW-H)-1:0]     phh4_reg;
    logic [EW+LH-1:0]        rll4_reg, rhl4_reg;
    logic [EW+LW-LH-1:0]     rlh4_reg, rhh4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_reg    <= s3_reg;
            d4_reg    <= d3_reg;
            aden4_reg <= aden_next;
            anum4_reg <= anum_next;
            deg4_reg  <= deg_next;
            zero4_reg <= zero_next;
            outs4_reg <= outs_next;
            pll4_reg  <= aden_next[H-1:0] * aden_next[H-1:0];
            plh4_reg  <= aden_next[H-1:0] * aden_next[MW-1:H];
            phh4_reg  <= aden_next[MW-1:H] * aden_next[MW-1:H];
            rll4_reg  <= peps2_3_reg[EW-1:0] * len2_3_reg[LH-1:0];
            rlh4_reg  <= peps2_3_reg[EW-1:0] * len2_3_reg[LW-1:LH];
            rhl4_reg  <= peps2_3_reg[2*EW-1:EW] * len2_3_reg[LH-1:0];
            rhh4_reg  <= peps2_3_reg[2*EW-1:EW] * len2_3_reg[LW-1:LH];
        end
    end

    // stage 5: exact parallel compare and classification
    logic [CW-1:0] lhs, rhs;
    reason_t       reason_next;

    always_comb begin
        lhs = (CW'(phh4_reg) << (2 * H)) + (CW'(plh4_reg) << (H + 1)) + CW'(pll4_reg);
        rhs = (CW'(rhh4_reg) << (EW + LH)) + (CW'(rhl4_reg) << EW)
              + (CW'(rlh4_reg) << LH) + CW'(rll4_reg);
        if (deg4_reg) begin
            reason_next = RSN_DEGENERATE;
        end else if (zero4_reg || (lhs < rhs)) begin
            reason_next = RSN_PARALLEL;
        end else if (outs4_reg) begin
            reason_next = RSN_OUT_SEGMENT;
        end else begin
            reason_next = RSN_HIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_data <= {reason_next, aden4_reg, anum4_reg,
                       d4_reg[2], d4_reg[1], d4_reg[0],
                       s4_reg[2], s4_reg[1], s4_reg[0]};
        end
    end

endmodule

### rtl/core/sri_back.sv
module sri_back #(
    parameter int COORD_WIDTH = sri_pkg::COORD_WIDTH_DEF,
    parameter int UNIT_FRAC   = sri_pkg::UNIT_FRAC_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [3*COORD_WIDTH-1:0]      rect_center,
    input  logic [3*COORD_WIDTH-1:0]      rect_right,
    input  logic [3*COORD_WIDTH-1:0]      rect_up,
    input  logic [2*COORD_WIDTH-1:0]      rect_size,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic [3*COORD_WIDTH + 3*(COORD_WIDTH+1) + 2*(2*COORD_WIDTH+3)
                  + sri_pkg::REASON_W - 1:0] q_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic [sri_pkg::REASON_W-1:0]  m_miss_reason,
    output logic signed [COORD_WIDTH-1:0] m_point_x,
    output logic signed [COORD_WIDTH-1:0] m_point_y,
    output logic signed [COORD_WIDTH-1:0] m_point_z
);
    import sri_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int SW  = 2 * W + 3;
    localparam int MW  = SW;
    localparam int H   = (MW + 1) / 2;
    localparam int DVW = DW + MW;
    localparam int XW  = (SW + 1 > W + UNIT_FRAC) ? SW + 1 : W + UNIT_FRAC;
    localparam int OS  = 3 * W + 3 * DW;

    logic en;
    assign en    = !m_valid || m_ready;
    assign q_pop = en && !q_empty;

    // unpack queue word
    logic signed [W-1:0]  q_s [3];
    logic signed [DW-1:0] q_d [3];
    logic [MW-1:0]        q_anum, q_aden;
    reason_t              q_reason;
    logic signed [W-1:0]  cen [3];
    logic signed [W-1:0]  rgt [3];
    logic signed [W-1:0]  upv [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_s[i] = q_data[i*W +: W];
            q_d[i] = q_data[3*W + i*DW +: DW];
            cen[i] = rect_center[i*W +: W];
            rgt[i] = rect_right[i*W +: W];
            upv[i] = rect_up[i*W +: W];
        end
        q_anum   = q_data[OS +: MW];
        q_aden   = q_data[OS + MW +: MW];
        q_reason = reason_t'(q_data[OS + 2*MW +: REASON_W]);
    end

    // stage a: offset numerator partial products
    logic                    va_reg;
    logic signed [W-1:0]     sa_reg [3];
    logic                    nega_reg [3];
    logic [MW-1:0]           adena_reg;
    reason_t                 rsna_reg;
    logic [DW+H-1:0]         ppl_reg [3];
    logic [DW+MW-H-1:0]      pph_reg [3];
    logic [DW-1:0]           dmag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dmag[i] = q_d[i][DW-1] ? DW'(-q_d[i]) : DW'(q_d[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= !q_empty;
        end
        if (en) begin
            sa_reg    <= q_s;
            adena_reg <= q_aden;
            rsna_reg  <= q_reason;
            for (int i = 0; i < 3; i++) begin
                nega_reg[i] <= q_d[i][DW-1];
                ppl_reg[i]  <= dmag[i] * q_anum[H-1:0];
                pph_reg[i]  <= dmag[i] * q_anum[MW-1:H];
            end
        end
    end

    // divider pipeline, one quotient bit per stage
    logic                dv_valid_reg [DW+1];
    logic signed [W-1:0] dv_s_reg [DW+1][3];
    logic                dv_neg_reg [DW+1][3];
    reason_t             dv_rsn_reg [DW+1];
    logic [MW-1:0]       dv_aden_reg [DW];
    logic [DVW-1:0]      dv_rem_reg [DW][3];
    logic [DW-1:0]       dv_q_reg [DW+1][3];

    // stage b: assemble dividends
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (en) begin
            dv_valid_reg[0] <= va_reg;
        end
        if (en) begin
            dv_s_reg[0]    <= sa_reg;
            dv_neg_reg[0]  <= nega_reg;
            dv_rsn_reg[0]  <= rsna_reg;
            dv_aden_reg[0] <= adena_reg;
            for (int i = 0; i < 3; i++) begin
                dv_rem_reg[0][i] <= DVW'(ppl_reg[i]) + (DVW'(pph_reg[i]) << H);
                dv_q_reg[0][i]   <= '0;
            end
        end
    end

    for (genvar k = 0; k < DW; k++) begin : g_div
        localparam int B = DW - 1 - k;
        logic [DVW-1:0] trial;
        logic [DVW-1:0] rem_next [3];
        logic [DW-1:0]  q_next [3];

        assign trial = DVW'(dv_aden_reg[k]) << B;

        // restoring step on all three axes
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rem_next[i] = dv_rem_reg[k][i];
                q_next[i]   = dv_q_reg[k][i];
                if (dv_rem_reg[k][i] >= trial) begin
                    rem_next[i]  = dv_rem_reg[k][i] - trial;
                    q_next[i][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
            if (en) begin
                dv_s_reg[k+1]   <= dv_s_reg[k];
                dv_neg_reg[k+1] <= dv_neg_reg[k];
                dv_rsn_reg[k+1] <= dv_rsn_reg[k];
                dv_q_reg[k+1]   <= q_next;
            end
        end

        if (k < DW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    dv_aden_reg[k+1] <= dv_aden_reg[k];
                    dv_rem_reg[k+1]  <= rem_next;
                end
            end
        end
    end

    // stage c: crossing point with saturation, offset from centre
    logic signed [W+1:0]  sum_c [3];
    logic signed [W-1:0]  p_next [3];
    logic signed [DW-1:0] pc_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dv_neg_reg[DW][i]) begin
                sum_c[i] = (W+2)'(dv_s_reg[DW][i]) - $signed({1'b0, dv_q_reg[DW][i]});
            end else begin
                sum_c[i] = (W+2)'(dv_s_reg[DW][i]) + $signed({1'b0, dv_q_reg[DW][i]});
            end
            if ((sum_c[i][W+1:W-1] == '0) || (sum_c[i][W+1:W-1] == '1)) begin
                p_next[i] = sum_c[i][W-1:0];
            end else if (sum_c[i][W+1]) begin
                p_next[i] = {1'b1, {(W-1){1'b0}}};
            end else begin
                p_next[i] = {1'b0, {(W-1){1'b1}}};
            end
            pc_next[i] = DW'(p_next[i]) - DW'(cen[i]);
        end
    end

    logic                 vc_reg;
    reason_t              rsnc_reg;
    logic signed [W-1:0]  pc_reg [3];
    logic signed [DW-1:0] off_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= dv_valid_reg[DW];
        end
        if (en) begin
            rsnc_reg <= dv_rsn_reg[DW];
            pc_reg   <= p_next;
            off_reg  <= pc_next;
        end
    end

    // stage d: projections onto the rectangle axes
    logic                   vd_reg;
    reason_t                rsnd_reg;
    logic signed [W-1:0]    pd_reg [3];
    logic signed [DW+W-1:0] prr_reg [3];
    logic signed [DW+W-1:0] pru_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= vc_reg;
        end
        if (en) begin
            rsnd_reg <= rsnc_reg;
            pd_reg   <= pc_reg;
            for (int i = 0; i < 3; i++) begin
                prr_reg[i] <= off_reg[i] * rgt[i];
                pru_reg[i] <= off_reg[i] * upv[i];
            end
        end
    end

    // stage e: extent test and result word
    logic signed [SW-1:0] dr, du;
    logic [SW-1:0]        mag_dr, mag_du;
    logic                 outside;
    reason_t              rsn_next;
    logic signed [W-1:0]  pt_next [3];

    always_comb begin
        dr      = SW'(prr_reg[0]) + SW'(prr_reg[1]) + SW'(prr_reg[2]);
        du      = SW'(pru_reg[0]) + SW'(pru_reg[1]) + SW'(pru_reg[2]);
        mag_dr  = dr[SW-1] ? SW'(-dr) : SW'(dr);
        mag_du  = du[SW-1] ? SW'(-du) : SW'(du);
        outside = ((XW'(mag_dr) << 1) > (XW'(rect_size[W-1:0]) << UNIT_FRAC))
                  || ((XW'(mag_du) << 1) > (XW'(rect_size[2*W-1:W]) << UNIT_FRAC));
        if (rsnd_reg == RSN_HIT) begin
            rsn_next = outside ? RSN_OUT_RECT : RSN_HIT;
            pt_next  = pd_reg;
        end else begin
            rsn_next = rsnd_reg;
            for (int i = 0; i < 3; i++) pt_next[i] = '0;
        end
    end

    logic                valid_out_reg;
    reason_t             rsn_out_reg;
    logic signed [W-1:0] pt_out_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_out_reg <= 1'b0;
        end else if (en) begin
            valid_out_reg <= vd_reg;
        end
        if (en) begin
            rsn_out_reg <= rsn_next;
            pt_out_reg  <= pt_next;
        end
    end

    assign m_valid       = valid_out_reg;
    assign m_hit         = (rsn_out_reg == RSN_HIT);
    assign m_miss_reason = rsn_out_reg;
    assign m_point_x     = pt_out_reg[0];
    assign m_point_y     = pt_out_reg[1];
    assign m_point_z     = pt_out_reg[2];

endmodule

### rtl/core/segment_rectangle_intersect_core.sv
// an accepted input word passes five front stages, the queue and the back pipeline
// throughput: one word per cycle while m_ready stays high, set by the one-bit-per-stage divider pipeline
// a four-word queue between classifier and divider lets each side stall alone
// reset: synchronous active low, clears valid state and loads register defaults
module segment_rectangle_intersect_core #(
    parameter int COORD_WIDTH = sri_pkg::COORD_WIDTH_DEF,
    parameter int COORD_FRAC  = sri_pkg::COORD_FRAC_DEF,
    parameter int UNIT_FRAC   = sri_pkg::UNIT_FRAC_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [3*COORD_WIDTH-1:0]      cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_start_x,
    input  logic signed [COORD_WIDTH-1:0] s_start_y,
    input  logic signed [COORD_WIDTH-1:0] s_start_z,
    input  logic signed [COORD_WIDTH-1:0] s_end_x,
    input  logic signed [COORD_WIDTH-1:0] s_end_y,
    input  logic signed [COORD_WIDTH-1:0] s_end_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic [sri_pkg::REASON_W-1:0]  m_miss_reason,
    output logic signed [COORD_WIDTH-1:0] m_point_x,
    output logic signed [COORD_WIDTH-1:0] m_point_y,
    output logic signed [COORD_WIDTH-1:0] m_point_z
);
    import sri_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int IW = 3*W + 3*(W+1) + 2*(2*W+3) + REASON_W;

    localparam logic [W-1:0]   UNIT_ONE  = W'(1 << UNIT_FRAC);
    localparam logic [W-1:0]   COORD_ONE = W'(1 << COORD_FRAC);
    localparam logic [3*W-1:0] NORMAL_RST = {UNIT_ONE, {(2*W){1'b0}}};
    localparam logic [3*W-1:0] RIGHT_RST  = {{(2*W){1'b0}}, UNIT_ONE};
    localparam logic [3*W-1:0] UP_RST     = {{W{1'b0}}, UNIT_ONE, {W{1'b0}}};
    localparam logic [2*W-1:0] SIZE_RST   = {COORD_ONE, COORD_ONE};

    logic [3*W-1:0]       center_reg, normal_reg, right_reg, up_reg;
    logic [2*W-1:0]       size_reg;
    logic [EPS_WIDTH-1:0] len_eps_reg, par_eps_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg  <= '0;
            normal_reg  <= NORMAL_RST;
            right_reg   <= RIGHT_RST;
            up_reg      <= UP_RST;
            size_reg    <= SIZE_RST;
            len_eps_reg <= EPS_WIDTH'(1);
            par_eps_reg <= EPS_WIDTH'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CENTER:  center_reg  <= cfg_data;
                CFG_NORMAL:  normal_reg  <= cfg_data;
                CFG_RIGHT:   right_reg   <= cfg_data;
                CFG_UP:      up_reg      <= cfg_data;
                CFG_SIZE:    size_reg    <= cfg_data[2*W-1:0];
                CFG_LEN_EPS: len_eps_reg <= cfg_data[EPS_WIDTH-1:0];
                CFG_PAR_EPS: par_eps_reg <= cfg_data[EPS_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    fifo_ctrl_t     q_ctrl;
    fifo_stat_t     q_stat;
    logic [IW-1:0]  q_wr_data, q_rd_data;
    logic           q_push, q_pop;

    assign q_ctrl.push = q_push;
    assign q_ctrl.pop  = q_pop;

    // classifier front
    sri_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_x        (s_start_x),
        .s_start_y        (s_start_y),
        .s_start_z        (s_start_z),
        .s_end_x          (s_end_x),
        .s_end_y          (s_end_y),
        .s_end_z          (s_end_z),
        .rect_center      (center_reg),
        .rect_normal      (normal_reg),
        .length_epsilon   (len_eps_reg),
        .parallel_epsilon (par_eps_reg),
        .q_full           (q_stat.full),
        .q_push           (q_push),
        .q_data           (q_wr_data)
    );

    // decoupling queue
    sri_fifo #(
        .DATA_WIDTH (IW)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (q_ctrl),
        .wr_data (q_wr_data),
        .stat    (q_stat),
        .rd_data (q_rd_data)
    );

    // divider and rectangle test back
    sri_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .UNIT_FRAC   (UNIT_FRAC)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rect_center   (center_reg),
        .rect_right    (right_reg),
        .rect_up       (up_reg),
        .rect_size     (size_reg),
        .q_empty       (q_stat.empty),
        .q_pop         (q_pop),
        .q_data        (q_rd_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_miss_reason (m_miss_reason),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_point_z     (m_point_z)
    );

endmodule

### bench/segment_rectangle_intersect_checker.sv
`timescale 1ns / 100ps

module segment_rectangle_intersect_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [62:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [20:0] s_start_x,
    input  logic signed [20:0] s_start_y,
    input  logic signed [20:0] s_start_z,
    input  logic signed [20:0] s_end_x,
    input  logic signed [20:0] s_end_y,
    input  logic signed [20:0] s_end_z,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_hit,
    input  logic [2:0]         m_miss_reason,
    input  logic signed [20:0] m_point_x,
    input  logic signed [20:0] m_point_y,
    input  logic signed [20:0] m_point_z,
    output int                 pending,
    output int                 errors
);
    import sri_pkg::*;

    localparam int W = 21;
    localparam int UFRAC = 19;

    typedef struct {
        logic               hit;
        reason_t            reason;
        logic signed [20:0] pt [3];
    } crossing_t;

    // local copy of the rectangle registers
    logic [62:0] center, normal, right_ax, up_ax;
    logic [41:0] size;
    logic [19:0] len_eps, par_eps;

    crossing_t expected_crossings [$];

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint slot(input logic [62:0] vec, input int i);
        logic signed [20:0] f;
        f = vec[i*W +: W];
        return longint'(f);
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > 64'sd1048575) return 64'sd1048575;
        if (v < -64'sd1048576) return -64'sd1048576;
        return v;
    endfunction

    // exact integer crossing test against the current rectangle
    function automatic crossing_t predict_crossing(input longint st [3], input longint en [3]);
        crossing_t res;
        longint d [3], cs [3], pc [3], p [3];
        longint num, den, dr, du, width, height, o;
        logic [63:0] len2, le2, eps2, anum, aden, prod, off;
        logic [127:0] lhs, rhs;
        bit have_point;
        have_point = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = en[i] - st[i];
            cs[i] = slot(center, i) - st[i];
            p[i] = 0;
        end
        width = longint'(size[20:0]);
        height = longint'(size[41:21]);
        len2 = 64'(d[0]*d[0] + d[1]*d[1] + d[2]*d[2]);
        den = d[0]*slot(normal, 0) + d[1]*slot(normal, 1) + d[2]*slot(normal, 2);
        num = cs[0]*slot(normal, 0) + cs[1]*slot(normal, 1) + cs[2]*slot(normal, 2);
        anum = magnitude(num);
        aden = magnitude(den);
        lhs = {64'd0, aden} * {64'd0, aden};
        eps2 = 64'(par_eps) * 64'(par_eps);
        rhs = {64'd0, eps2} * {64'd0, len2};
        le2 = 64'(len_eps) * 64'(len_eps);
        if (len2 < le2) begin
            res.reason = RSN_DEGENERATE;
        end else if (den == 0 || lhs < rhs) begin
            res.reason = RSN_PARALLEL;
        end else if ((num != 0 && ((num < 0) != (den < 0))) || anum > aden) begin
            res.reason = RSN_OUT_SEGMENT;
        end else begin
            // per-axis offset truncated toward zero, product wraps at 64 bits
            for (int i = 0; i < 3; i++) begin
                prod = magnitude(d[i]) * anum;
                off = prod / aden;
                o = longint'(off);
                p[i] = clamp_coord(st[i] + (d[i] < 0 ? -o : o));
                pc[i] = p[i] - slot(center, i);
            end
            have_point = 1;
            dr = pc[0]*slot(right_ax, 0) + pc[1]*slot(right_ax, 1) + pc[2]*slot(right_ax, 2);
            du = pc[0]*slot(up_ax, 0) + pc[1]*slot(up_ax, 1) + pc[2]*slot(up_ax, 2);
            if ($signed(64'd2 * magnitude(dr)) > (width <<< UFRAC) ||
                $signed(64'd2 * magnitude(du)) > (height <<< UFRAC))
                res.reason = RSN_OUT_RECT;
            else
                res.reason = RSN_HIT;
        end
        res.hit = (res.reason == RSN_HIT);
        for (int i = 0; i < 3; i++)
            res.pt[i] = have_point ? p[i][20:0] : '0;
        return res;
    endfunction

    assign pending = expected_crossings.size();

    initial errors = 0;

    // register writes, input words and result words seen at the rising edge
    always @(posedge aclk) begin
        crossing_t want;
        longint st [3], en [3];
        logic signed [20:0] got [3];
        if (!aresetn) begin
            center <= '0;
            normal <= 63'(64'd1 << UFRAC) << (2 * W);
            right_ax <= 63'(64'd1 << UFRAC);
            up_ax <= 63'(64'd1 << UFRAC) << W;
            size <= 42'(64'd1024) | (42'(64'd1024) << W);
            len_eps <= 20'd1;
            par_eps <= 20'd1;
            expected_crossings.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CENTER:  center <= cfg_data;
                    CFG_NORMAL:  normal <= cfg_data;
                    CFG_RIGHT:   right_ax <= cfg_data;
                    CFG_UP:      up_ax <= cfg_data;
                    CFG_SIZE:    size <= cfg_data[41:0];
                    CFG_LEN_EPS: len_eps <= cfg_data[19:0];
                    CFG_PAR_EPS: par_eps <= cfg_data[19:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                st[0] = s_start_x; st[1] = s_start_y; st[2] = s_start_z;
                en[0] = s_end_x;   en[1] = s_end_y;   en[2] = s_end_z;
                expected_crossings.push_back(predict_crossing(st, en));
            end
            if (m_valid && m_ready) begin
                if (expected_crossings.size() == 0) begin
                    $display("%0t: unexpected result word hit=%0b reason=%0d",
                             $time, m_hit, m_miss_reason);
                    errors++;
                end else begin
                    want = expected_crossings.pop_front();
                    got[0] = m_point_x; got[1] = m_point_y; got[2] = m_point_z;
                    if (m_hit !== want.hit) begin
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit, m_hit);
                        errors++;
                    end
                    if (m_miss_reason !== want.reason) begin
                        $display("%0t: miss_reason expected %0d actual %0d",
                                 $time, want.reason, m_miss_reason);
                        errors++;
                    end
                    for (int i = 0; i < 3; i++) begin
                        if (got[i] !== want.pt[i]) begin
                            $display("%0t: point axis %0d expected %0d actual %0d",
                                     $time, i, want.pt[i], got[i]);
                            errors++;
                        end
                    end
                end
            end
        end
    end

endmodule

### bench/segment_rectangle_intersect_core_tb.sv
`timescale 1ns / 100ps

module segment_rectangle_intersect_core_tb;
    import sri_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int ONE_UNIT = 524288;
    localparam int SETTLE = 45;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = CFG_CENTER;
    logic [62:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [20:0] s_start_x = '0, s_start_y = '0, s_start_z = '0;
    logic signed [20:0] s_end_x = '0, s_end_y = '0, s_end_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;
    logic [2:0] m_miss_reason;
    logic signed [20:0] m_point_x, m_point_y, m_point_z;
    int pending, errors;

    // rectangle centre as last written, used to aim segments
    int centre [3];
    bit no_gaps;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    segment_rectangle_intersect_core dut (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_start_x, .s_start_y, .s_start_z,
        .s_end_x, .s_end_y, .s_end_z,
        .m_valid, .m_ready, .m_hit, .m_miss_reason,
        .m_point_x, .m_point_y, .m_point_z
    );

    segment_rectangle_intersect_checker checker_i (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_start_x, .s_start_y, .s_start_z,
        .s_end_x, .s_end_y, .s_end_z,
        .m_valid, .m_ready, .m_hit, .m_miss_reason,
        .m_point_x, .m_point_y, .m_point_z,
        .pending, .errors
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [62:0] pack_vec(input int x, input int y, input int z);
        return {21'(z), 21'(y), 21'(x)};
    endfunction

    function automatic int clip21(input int v);
        if (v > 1048575) return 1048575;
        if (v < -1048576) return -1048576;
        return v;
    endfunction

    function automatic int rand_coord();
        return $signed(21'($urandom));
    endfunction

    // one of the six axis directions or a random vector
    function automatic logic [62:0] rand_dir();
        int v [3];
        int k;
        v = '{0, 0, 0};
        if ($urandom_range(0, 2) != 0) begin
            k = $urandom_range(0, 2);
            v[k] = $urandom_range(0, 1) ? ONE_UNIT : -ONE_UNIT;
        end else begin
            for (int i = 0; i < 3; i++)
                v[i] = $urandom_range(0, 2 * ONE_UNIT) - ONE_UNIT;
        end
        return pack_vec(v[0], v[1], v[2]);
    endfunction

    // result side stalls
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0 && !no_gaps) begin
                m_ready = 1'b0;
                stall--;
            end else begin
                m_ready = 1'b1;
                stall = ($urandom_range(0, 7) == 0) ? gap_len() : 0;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [62:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        if (idx == CFG_CENTER)
            for (int i = 0; i < 3; i++)
                centre[i] = $signed(value[i*21 +: 21]);
    endtask

    task automatic send_segment(input int sx, input int sy, input int sz,
                                input int ex, input int ey, input int ez);
        int g;
        g = no_gaps ? 0 : gap_len();
        if (g > 0) begin
            s_valid = 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_start_x = sx; s_start_y = sy; s_start_z = sz;
        s_end_x = ex;   s_end_y = ey;   s_end_z = ez;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_all(input logic [62:0] c, input logic [62:0] n,
                             input logic [62:0] r, input logic [62:0] u,
                             input logic [62:0] sz, input logic [62:0] le,
                             input logic [62:0] pe);
        write_reg(CFG_CENTER, c);
        write_reg(CFG_NORMAL, n);
        write_reg(CFG_RIGHT, r);
        write_reg(CFG_UP, u);
        write_reg(CFG_SIZE, sz);
        write_reg(CFG_LEN_EPS, le);
        write_reg(CFG_PAR_EPS, pe);
    endtask

    initial begin
        int off [6];
        centre = '{0, 0, 0};
        no_gaps = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed words against the reset rectangle (unit square in z = 0)
        send_segment(100, 100, -1024, 100, 100, 1024);       // hit
        send_segment(-512, 512, -2048, -512, 512, 0);         // hit at corner, end on plane
        send_segment(0, 0, 0, 0, 0, 4096);                     // start on plane
        send_segment(300, 300, 300, 300, 300, 300);           // degenerate
        send_segment(0, 0, 500, 1, 0, 500);                   // length one, not degenerate
        send_segment(0, 0, 500, 4000, 0, 500);                // parallel
        send_segment(0, 0, 500, 0, 0, 1000);                  // crossing before start
        send_segment(0, 0, -2000, 0, 0, -1000);               // crossing past end
        send_segment(5000, 0, -1024, 5000, 0, 1024);          // outside rectangle
        send_segment(0, 600, -1024, 0, 600, 1024);            // just outside height
        send_segment(513, 0, -1024, 513, 0, 1024);            // just outside width
        send_segment(-1048576, -1048576, -1048576, 1048575, 1048575, 1048575);
        send_segment(1048575, 1048575, 1048575, -1048576, -1048576, -1048576);
        send_segment(-1048576, 1048575, -1048576, 1048575, -1048576, 1048575);
        send_segment(1048575, -1048576, -1048576, -1048576, 1048575, 1048575);
        send_segment(0, 0, -1048576, 1048575, 1048575, 1048575); // crossing point far outside rectangle
        send_segment(1048575, 0, -1048576, -1048576, 0, 4);
        send_segment(0, 0, -1, 0, 0, 1);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            no_gaps = (phase == 3);
            case (phase)
                0: write_all('1, '1, '1, '1, '1, '1, '1);
                1: write_all('0, '0, '0, '0, '0, '0, '0);
                2: write_all(pack_vec(1024, -2048, 3072), pack_vec(ONE_UNIT, 0, 0),
                             pack_vec(0, ONE_UNIT, 0), pack_vec(0, 0, ONE_UNIT),
                             63'({21'd2097151, 21'd2097151}), 63'd0, 63'd524288);
                3: write_all(pack_vec(0, 0, 0), pack_vec(0, 0, ONE_UNIT),
                             pack_vec(ONE_UNIT, 0, 0), pack_vec(0, ONE_UNIT, 0),
                             63'({21'd4096, 21'd2048}), 63'd1048575, 63'd0);
                4: write_all(63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                             63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                             63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                             63'({$urandom, $urandom}));
                default: write_all(pack_vec($urandom_range(0, 8192) - 4096,
                                            $urandom_range(0, 8192) - 4096,
                                            $urandom_range(0, 8192) - 4096),
                                   rand_dir(), rand_dir(), rand_dir(),
                                   63'({21'($urandom_range(0, 8192)),
                                        21'($urandom_range(0, 8192))}),
                                   63'($urandom_range(0, 64)),
                                   63'($urandom_range(0, 20000)));
            endcase
            // a write past the register list must change nothing
            write_reg(CFG_UNUSED, 63'({$urandom, $urandom}));

            for (int k = 0; k < 100; k++) begin
                if (phase != 3 && k % 40 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) < 7) begin
                    // segment aimed through the neighbourhood of the centre
                    for (int i = 0; i < 6; i++)
                        off[i] = $urandom_range(0, 8192) - 4096;
                    send_segment(clip21(centre[0] + off[0]), clip21(centre[1] + off[1]),
                                 clip21(centre[2] + off[2]), clip21(centre[0] - off[3]),
                                 clip21(centre[1] - off[4]), clip21(centre[2] - off[5]));
                end else begin
                    send_segment(rand_coord(), rand_coord(), rand_coord(),
                                 rand_coord(), rand_coord(), rand_coord());
                end
            end
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/sri_pkg.sv
rtl/core/sri_fifo.sv
rtl/core/sri_front.sv
rtl/core/sri_back.sv
rtl/core/segment_rectangle_intersect_core.sv
bench/segment_rectangle_intersect_checker.sv
bench/segment_rectangle_intersect_core_tb.sv
